FILE: rtl/uls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uls_pkg: shared types and constants of the upwind level-set advection core
// Transaction payloads, configuration set, controller commands and status,
// grid sizing and register map.
// ----------------------------------------------------------------------------
package uls_pkg;

	// Grid sizing
	localparam int MAX_COLS = 64;
	localparam int MAX_ROWS = 64;
	localparam int CELLS    = MAX_COLS * MAX_ROWS;
	localparam int ADDR_W   = $clog2(CELLS);

	// Field widths fixed by the interface
	localparam int COL_W  = 6;
	localparam int ROW_W  = 6;
	localparam int DIM_W  = 7;
	localparam int DT_W   = 31;
	localparam int DATA_W = 32;

	// Configuration port
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_TIME_STEP   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_COLS_IN_USE = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_ROWS_IN_USE = 2'd2;

	// Item kinds
	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_COMPUTE = 1'b1;

	typedef struct packed {
		logic                     kind;
		logic [COL_W-1:0]         col;
		logic [ROW_W-1:0]         row;
		logic signed [DATA_W-1:0] level_value;
		logic signed [DATA_W-1:0] vel_x;
		logic signed [DATA_W-1:0] vel_y;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] new_level;
		logic                     saturated;
	} out_item_t;

	typedef struct packed {
		logic [DT_W-1:0]  time_step;
		logic [DIM_W-1:0] cols_in_use;
		logic [DIM_W-1:0] rows_in_use;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic wr_en;
		logic rd_here;
		logic rd_nbr;
		logic diff_en;
		logic mul_en;
		logic sum_en;
		logic dt_en;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

FILE: rtl/uls_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uls_ram: generic single-write, single-read RAM
// One write port and one read port; read data registered, held while idle.
// ----------------------------------------------------------------------------
module uls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/uls_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uls_regs: configuration register file
// APB-style slave holding time step and grid dimensions; always ready.
// ----------------------------------------------------------------------------
module uls_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [uls_pkg::PADDR_W-1:0]   paddr,
	input  logic [uls_pkg::PDATA_W-1:0]   pwdata,
	output logic [uls_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output uls_pkg::cfg_t                 cfg
);
	import uls_pkg::*;

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_stb;
	cfg_t                 cfg_q;

	assign reg_idx = paddr[REG_IDX_W+1:2];
	assign wr_stb  = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// Write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.time_step   <= '0;
			cfg_q.cols_in_use <= DIM_W'(64);
			cfg_q.rows_in_use <= DIM_W'(64);
		end else if (wr_stb) begin
			case (reg_idx)
				REG_TIME_STEP:   cfg_q.time_step   <= pwdata[DT_W-1:0];
				REG_COLS_IN_USE: cfg_q.cols_in_use <= pwdata[DIM_W-1:0];
				REG_ROWS_IN_USE: cfg_q.rows_in_use <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			REG_TIME_STEP:   prdata = PDATA_W'(cfg_q.time_step);
			REG_COLS_IN_USE: prdata = PDATA_W'(cfg_q.cols_in_use);
			REG_ROWS_IN_USE: prdata = PDATA_W'(cfg_q.rows_in_use);
			default:         prdata = '0;
		endcase
	end

endmodule

FILE: rtl/uls_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uls_ctrl: sequencing controller
// Accepts one transaction at a time and steps the datapath through load or
// compute phases, then hands the result to the output register.
// ----------------------------------------------------------------------------
module uls_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_kind,
	output logic                in_stall,
	input  uls_pkg::dp_status_t status,
	output uls_pkg::ctrl_cmd_t  cmd
);
	import uls_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LOAD = 4'd1;
	localparam logic [3:0] S_RD0  = 4'd2;
	localparam logic [3:0] S_RD1  = 4'd3;
	localparam logic [3:0] S_DIFF = 4'd4;
	localparam logic [3:0] S_MUL  = 4'd5;
	localparam logic [3:0] S_SUM  = 4'd6;
	localparam logic [3:0] S_DT   = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = (in_kind == KIND_LOAD) ? S_LOAD : S_RD0;
				end
			end
			S_LOAD: begin
				cmd.wr_en = 1'b1;
				state_d   = S_DONE;
			end
			S_RD0: begin
				cmd.rd_here = 1'b1;
				state_d     = S_RD1;
			end
			S_RD1: begin
				cmd.rd_nbr = 1'b1;
				state_d    = S_DIFF;
			end
			S_DIFF: begin
				cmd.diff_en = 1'b1;
				state_d     = S_MUL;
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = S_SUM;
			end
			S_SUM: begin
				cmd.sum_en = 1'b1;
				state_d    = S_DT;
			end
			S_DT: begin
				cmd.dt_en = 1'b1;
				state_d   = S_DONE;
			end
			S_DONE: begin
				cmd.out_load = status.out_free;
				if (status.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/uls_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uls_dp: advection datapath
// Grid stores, neighbour selection, velocity products, time-step scaling,
// saturation and the output register.
// ----------------------------------------------------------------------------
module uls_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  uls_pkg::cfg_t       cfg,
	input  uls_pkg::ctrl_cmd_t  cmd,
	output uls_pkg::dp_status_t status,
	input  uls_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output uls_pkg::out_item_t  out_item
);
	import uls_pkg::*;

	function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
		cell_addr = ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c));
	endfunction

	function automatic logic signed [DATA_W:0] diff33(logic [DATA_W-1:0] a,
		logic [DATA_W-1:0] b);
		diff33 = $signed({a[DATA_W-1], a}) - $signed({b[DATA_W-1], b});
	endfunction

	function automatic logic [DATA_W-1:0] mag33(logic [DATA_W:0] v);
		logic [DATA_W:0] n;
		n = v[DATA_W] ? (~v + 1'b1) : v;
		mag33 = n[DATA_W-1:0];
	endfunction

	function automatic logic signed [49:0] signed_term(logic [47:0] m, logic neg);
		logic signed [49:0] e;
		e = $signed({2'b00, m});
		signed_term = neg ? -e : e;
	endfunction

	// Item capture
	in_item_t item_q;
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_item;
		end
	end

	// Grid dimensions in use, clamped to the store
	logic [DIM_W-1:0] ncols, nrows, ncols_m1, nrows_m1;
	always_comb begin
		ncols = cfg.cols_in_use;
		if (cfg.cols_in_use < DIM_W'(2)) begin
			ncols = DIM_W'(2);
		end else if (int'(cfg.cols_in_use) > MAX_COLS) begin
			ncols = DIM_W'(MAX_COLS);
		end
		nrows = cfg.rows_in_use;
		if (cfg.rows_in_use < DIM_W'(2)) begin
			nrows = DIM_W'(2);
		end else if (int'(cfg.rows_in_use) > MAX_ROWS) begin
			nrows = DIM_W'(MAX_ROWS);
		end
		ncols_m1 = ncols - DIM_W'(1);
		nrows_m1 = nrows - DIM_W'(1);
	end

	// Clamp the compute cell onto the grid
	logic [COL_W-1:0]  ci;
	logic [ROW_W-1:0]  cj;
	logic [ADDR_W-1:0] here_addr;
	always_comb begin
		ci = item_q.col;
		if (DIM_W'(item_q.col) > ncols_m1) begin
			ci = ncols_m1[COL_W-1:0];
		end
		cj = item_q.row;
		if (DIM_W'(item_q.row) > nrows_m1) begin
			cj = nrows_m1[ROW_W-1:0];
		end
		here_addr = cell_addr(cj, ci);
	end

	logic [COL_W-1:0]  ci_q;
	logic [ROW_W-1:0]  cj_q;
	logic [ADDR_W-1:0] here_q;
	always_ff @(posedge clk) begin
		if (cmd.rd_here) begin
			ci_q   <= ci;
			cj_q   <= cj;
			here_q <= here_addr;
		end
	end

	// Stores: two copies of the level set for the two neighbour reads
	logic                  wr_en;
	logic [ADDR_W-1:0]     wr_addr;
	logic [DATA_W-1:0]     lvl_a_rdata, lvl_b_rdata;
	logic [2*DATA_W-1:0]   vel_rdata;
	logic [ADDR_W-1:0]     lvl_a_raddr, nbr_x_addr, nbr_y_addr;

	assign wr_en   = cmd.wr_en && (int'(item_q.col) < MAX_COLS)
		&& (int'(item_q.row) < MAX_ROWS);
	assign wr_addr = cell_addr(item_q.row, item_q.col);
	assign lvl_a_raddr = cmd.rd_here ? here_addr : nbr_x_addr;

	uls_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_lvl_a (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (item_q.level_value),
		.re    (cmd.rd_here || cmd.rd_nbr),
		.raddr (lvl_a_raddr),
		.rdata (lvl_a_rdata)
	);

	uls_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_lvl_b (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (item_q.level_value),
		.re    (cmd.rd_nbr),
		.raddr (nbr_y_addr),
		.rdata (lvl_b_rdata)
	);

	uls_ram #(.WIDTH(2*DATA_W), .DEPTH(CELLS)) u_vel (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata ({item_q.vel_x, item_q.vel_y}),
		.re    (cmd.rd_here),
		.raddr (here_addr),
		.rdata (vel_rdata)
	);

	// Choose the upwind neighbour from the sign of each velocity
	logic [DATA_W-1:0] vx_rd, vy_rd;
	logic              fwd_x, fwd_y;
	assign vx_rd = vel_rdata[2*DATA_W-1:DATA_W];
	assign vy_rd = vel_rdata[DATA_W-1:0];
	always_comb begin
		fwd_x = (ci_q == '0) || ((DIM_W'(ci_q) != ncols_m1)
			&& !vx_rd[DATA_W-1] && (vx_rd != '0));
		fwd_y = (cj_q == '0) || ((DIM_W'(cj_q) != nrows_m1)
			&& !vy_rd[DATA_W-1] && (vy_rd != '0));
		nbr_x_addr = fwd_x ? (here_q + ADDR_W'(1)) : (here_q - ADDR_W'(1));
		nbr_y_addr = fwd_y ? (here_q + ADDR_W'(MAX_COLS)) : (here_q - ADDR_W'(MAX_COLS));
	end

	logic [DATA_W-1:0] phi_q, vx_q, vy_q;
	logic              fwdx_q, fwdy_q;
	always_ff @(posedge clk) begin
		if (cmd.rd_nbr) begin
			phi_q  <= lvl_a_rdata;
			vx_q   <= vx_rd;
			vy_q   <= vy_rd;
			fwdx_q <= fwd_x;
			fwdy_q <= fwd_y;
		end
	end

	// One-sided differences
	logic signed [DATA_W:0] px_q, py_q;
	always_ff @(posedge clk) begin
		if (cmd.diff_en) begin
			px_q <= fwdx_q ? diff33(lvl_a_rdata, phi_q) : diff33(phi_q, lvl_a_rdata);
			py_q <= fwdy_q ? diff33(lvl_b_rdata, phi_q) : diff33(phi_q, lvl_b_rdata);
		end
	end

	// Velocity products on magnitudes
	logic [2*DATA_W-1:0] prodx_q, prody_q;
	logic                negx_q, negy_q;
	logic [DATA_W-1:0]   ax, ay, apx, apy;
	always_comb begin
		ax  = mag33({vx_q[DATA_W-1], vx_q});
		ay  = mag33({vy_q[DATA_W-1], vy_q});
		apx = mag33(px_q);
		apy = mag33(py_q);
	end
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prodx_q <= ax * apx;
			prody_q <= ay * apy;
			negx_q  <= vx_q[DATA_W-1] ^ px_q[DATA_W];
			negy_q  <= vy_q[DATA_W-1] ^ py_q[DATA_W];
		end
	end

	// Truncate each term toward zero and sum
	logic signed [49:0] sum_q;
	always_ff @(posedge clk) begin
		if (cmd.sum_en) begin
			sum_q <= signed_term(prodx_q[63:16], negx_q) + signed_term(prody_q[63:16], negy_q);
		end
	end

	// Scale by the time step in two partial products
	logic [49:0] msum;
	logic [25:0] hi_raw;
	logic [23:0] hi24;
	logic [54:0] dth_q, dtl_q;
	logic        sneg_q;
	always_comb begin
		msum   = sum_q[49] ? (~sum_q + 1'b1) : sum_q;
		hi_raw = msum[49:24];
		hi24   = (|hi_raw[25:24]) ? 24'hFF_FFFF : hi_raw[23:0];
	end
	always_ff @(posedge clk) begin
		if (cmd.dt_en) begin
			dth_q  <= cfg.time_step * hi24;
			dtl_q  <= cfg.time_step * msum[23:0];
			sneg_q <= sum_q[49];
		end
	end

	// Combine, cap, add phi and saturate
	logic [63:0]        r_full;
	logic [40:0]        r_cap;
	logic signed [42:0] sval, total;
	logic               sat_hi, sat_lo;
	out_item_t          result;
	always_comb begin
		r_full = {1'b0, dth_q, 8'd0} + 64'(dtl_q[54:16]);
		r_cap  = (r_full > (64'd1 << 40)) ? (41'd1 << 40) : r_full[40:0];
		sval   = sneg_q ? -$signed({2'b00, r_cap}) : $signed({2'b00, r_cap});
		total  = sval + $signed({{11{phi_q[DATA_W-1]}}, phi_q});
		sat_hi = !total[42] && (|total[42:31]);
		sat_lo = total[42] && !(&total[42:31]);
		result.saturated = sat_hi || sat_lo;
		if (sat_hi) begin
			result.new_level = 32'sh7FFF_FFFF;
		end else if (sat_lo) begin
			result.new_level = 32'sh8000_0000;
		end else begin
			result.new_level = total[31:0];
		end
	end

	// Output register: hold until the transaction is taken
	logic      out_valid_q;
	out_item_t out_item_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_item_q <= (item_q.kind == KIND_LOAD) ? '0 : result;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_item        = out_item_q;
	assign status.out_free = !out_valid_q || !out_stall;

endmodule

FILE: rtl/upwind_level_set_advection_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upwind_level_set_advection_core: first-order upwind level-set advection
// Grid stores for phi, vx and vy; load transactions write a cell, compute
// transactions return dt*(vx*px + vy*py) + phi with saturation.
// ----------------------------------------------------------------------------
// Load: the item is captured, written to the stores and handed over. Compute:
// here and neighbour reads, difference, velocity products, sum, time-step
// scaling, hand-over. A new transaction is taken only after the previous one
// has been handed over. A held result stalls the next one at hand-over, and the input.
// Reset clears the controller, output valid and configuration (dt 0, 64 x 64);
// the grid stores are not cleared and need no clearing pass.
module upwind_level_set_advection_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [uls_pkg::PADDR_W-1:0] paddr,
	input  logic [uls_pkg::PDATA_W-1:0] pwdata,
	output logic [uls_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  uls_pkg::in_item_t           in_item,
	output logic                        out_valid,
	input  logic                        out_stall,
	output uls_pkg::out_item_t          out_item
);
	import uls_pkg::*;

	cfg_t       cfg;
	ctrl_cmd_t  ctrl_cmd;
	dp_status_t dp_status;

	uls_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	uls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_kind  (in_item.kind),
		.in_stall (in_stall),
		.status   (dp_status),
		.cmd      (ctrl_cmd)
	);

	uls_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (ctrl_cmd),
		.status    (dp_status),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	// An accepted transaction keeps the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("block not busy after accepting a transaction");

	// A load writes the stores exactly once
	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_cmd.wr_en |=> !ctrl_cmd.wr_en)
		else $error("store written on consecutive cycles");

	// A handed-over result shows up as valid output
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_cmd.out_load |=> out_valid)
		else $error("result loaded but output not valid");

	// Neighbour read always follows the centre read
	a_read_order: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_cmd.rd_nbr |-> $past(ctrl_cmd.rd_here))
		else $error("neighbour read without preceding centre read");

	// A clipped result sits at one of the range limits
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.saturated) |->
		(out_item.new_level == 32'sh7FFF_FFFF || out_item.new_level == 32'sh8000_0000))
		else $error("saturated result not at a range limit");

endmodule
